// File: sv/sbi_pkg.sv
// Shared constants and types for the segment versus box intersection core.
package sbi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int NUM_AXES        = 3;
  localparam int NUM_PLANES      = 6;
  localparam int NUM_FIELDS      = 12;
  localparam int OUT_TDATA_W     = 8;

  typedef struct packed {
    logic valid;
    logic reject;
    logic in_box;
  } ctl_t;

  // lo, hi, A (3 coords each), |B-A| per axis, sign of B-A per axis, crossing flag per plane
  function automatic int side_width(input int cw);
    return 9 * cw + NUM_AXES * (cw + 1) + NUM_AXES + NUM_PLANES;
  endfunction

endpackage

// File: sv/segment_box_intersect_core.sv
// Top level of the segment versus axis-aligned box intersection core.
// Takes one request per cycle and returns one flag per request, in order. The pipeline is
// an input register, a front stage, one restoring division step per fraction bit for the
// six face planes in parallel, a product stage and a containment stage.
// All stages advance together; when the result is not taken the whole pipe holds.
module segment_box_intersect_core #(
  parameter int COORD_WIDTH = sbi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sbi_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // seg_a_x, seg_a_y, seg_a_z, seg_b_x, seg_b_y, seg_b_z
  input  logic [((sbi_pkg::NUM_FIELDS*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // hits_box
  output logic [sbi_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import sbi_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int YW = W + 2;
  localparam int TW = FRAC_BITS > 0 ? FRAC_BITS : 1;
  localparam int SW = side_width(W);
  localparam int FW = NUM_FIELDS * W;

  logic                 en;
  logic                 in_valid_r;
  logic [FW-1:0]        in_data_r;
  logic signed [W-1:0]  lo_c [NUM_AXES];
  logic signed [W-1:0]  hi_c [NUM_AXES];
  logic signed [W-1:0]  a_c  [NUM_AXES];
  logic signed [W-1:0]  b_c  [NUM_AXES];

  ctl_t                 ctl_s  [FRAC_BITS+1];
  logic [SW-1:0]        side_s [FRAC_BITS+1];
  logic [YW-1:0]        r_s    [FRAC_BITS+1][NUM_PLANES];
  logic [YW-1:0]        d_s    [FRAC_BITS+1][NUM_PLANES];
  logic [TW-1:0]        t_s    [FRAC_BITS+1][NUM_PLANES];
  logic                 hit;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (en) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_data_r <= in_tdata[FW-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      lo_c[k] = in_data_r[k*W +: W];
      hi_c[k] = in_data_r[(NUM_AXES+k)*W +: W];
      a_c[k]  = in_data_r[(2*NUM_AXES+k)*W +: W];
      b_c[k]  = in_data_r[(3*NUM_AXES+k)*W +: W];
    end
  end

  sbi_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid_r),
    .lo_i    (lo_c),
    .hi_i    (hi_c),
    .a_i     (a_c),
    .b_i     (b_c),
    .ctl_o   (ctl_s[0]),
    .side_o  (side_s[0]),
    .r_o     (r_s[0]),
    .d_o     (d_s[0])
  );

  assign t_s[0] = '{default: '0};

  for (genvar s = 0; s < FRAC_BITS; s++) begin : g_div
    sbi_div_step #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl_s[s]),
      .side_i (side_s[s]),
      .r_i    (r_s[s]),
      .d_i    (d_s[s]),
      .t_i    (t_s[s]),
      .ctl_o  (ctl_s[s+1]),
      .side_o (side_s[s+1]),
      .r_o    (r_s[s+1]),
      .d_o    (d_s[s+1]),
      .t_o    (t_s[s+1])
    );
  end

  sbi_finish #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_finish (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_i   (ctl_s[FRAC_BITS]),
    .side_i  (side_s[FRAC_BITS]),
    .t_i     (t_s[FRAC_BITS]),
    .valid_o (out_tvalid),
    .hit_o   (hit)
  );

  assign out_tdata = {{(OUT_TDATA_W-1){1'b0}}, hit};

endmodule

// File: sv/sbi_prep.sv
// Front stage: trivial reject, inside test, plane distances and edge deltas.
module sbi_prep #(
  parameter int COORD_WIDTH = sbi_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              valid_i,
  input  logic signed [COORD_WIDTH-1:0]     lo_i [sbi_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0]     hi_i [sbi_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0]     a_i  [sbi_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0]     b_i  [sbi_pkg::NUM_AXES],
  output sbi_pkg::ctl_t                     ctl_o,
  output logic [sbi_pkg::side_width(COORD_WIDTH)-1:0] side_o,
  output logic [COORD_WIDTH+1:0]            r_o [sbi_pkg::NUM_PLANES],
  output logic [COORD_WIDTH+1:0]            d_o [sbi_pkg::NUM_PLANES]
);
  import sbi_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int XW = W + 1;
  localparam int YW = W + 2;
  localparam int SW = side_width(W);
  localparam int MAG_OFS = 9 * W;
  localparam int NEG_OFS = MAG_OFS + NUM_AXES * XW;
  localparam int CRS_OFS = NEG_OFS + NUM_AXES;

  logic signed [XW-1:0] da_c [NUM_PLANES];
  logic signed [XW-1:0] db_c [NUM_PLANES];
  logic signed [XW-1:0] dl_c [NUM_AXES];
  logic [XW-1:0]        na_c [NUM_PLANES];
  logic [XW-1:0]        nb_c [NUM_PLANES];
  logic [YW-1:0]        d_c  [NUM_PLANES];
  logic [SW-1:0]        side_c;
  logic                 reject_c;
  logic                 inside_c;

  ctl_t                 ctl_r;
  logic [SW-1:0]        side_r;
  logic [YW-1:0]        r_r [NUM_PLANES];
  logic [YW-1:0]        d_r [NUM_PLANES];

  always_comb begin
    reject_c = 1'b0;
    inside_c = 1'b1;
    side_c   = '0;
    for (int k = 0; k < NUM_AXES; k++) begin
      if ((b_i[k] < lo_i[k] && a_i[k] < lo_i[k]) || (b_i[k] > hi_i[k] && a_i[k] > hi_i[k])) begin
        reject_c = 1'b1;
      end
      if (!(a_i[k] > lo_i[k] && a_i[k] < hi_i[k])) begin
        inside_c = 1'b0;
      end
      dl_c[k] = XW'(b_i[k]) - XW'(a_i[k]);
      side_c[k*W +: W]              = lo_i[k];
      side_c[(NUM_AXES+k)*W +: W]   = hi_i[k];
      side_c[(2*NUM_AXES+k)*W +: W] = a_i[k];
      side_c[MAG_OFS + k*XW +: XW]  = dl_c[k] < 0 ? $unsigned(-dl_c[k]) : $unsigned(dl_c[k]);
      side_c[NEG_OFS + k]           = dl_c[k] < 0;
    end
    for (int p = 0; p < NUM_PLANES; p++) begin
      da_c[p] = XW'(a_i[p % NUM_AXES])
              - XW'((p < NUM_AXES) ? lo_i[p % NUM_AXES] : hi_i[p % NUM_AXES]);
      db_c[p] = XW'(b_i[p % NUM_AXES])
              - XW'((p < NUM_AXES) ? lo_i[p % NUM_AXES] : hi_i[p % NUM_AXES]);
      na_c[p] = da_c[p] < 0 ? $unsigned(-da_c[p]) : $unsigned(da_c[p]);
      nb_c[p] = db_c[p] < 0 ? $unsigned(-db_c[p]) : $unsigned(db_c[p]);
      d_c[p]  = YW'(na_c[p]) + YW'(nb_c[p]);
      side_c[CRS_OFS + p] = (da_c[p] < 0 && db_c[p] > 0) || (da_c[p] > 0 && db_c[p] < 0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r.valid  <= valid_i;
      ctl_r.reject <= reject_c;
      ctl_r.in_box <= inside_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_c;
      for (int p = 0; p < NUM_PLANES; p++) begin
        r_r[p] <= YW'(na_c[p]);
        d_r[p] <= d_c[p];
      end
    end
  end

  assign ctl_o  = ctl_r;
  assign side_o = side_r;
  assign r_o    = r_r;
  assign d_o    = d_r;

endmodule

// File: sv/sbi_div_step.sv
// One restoring division step for all six face planes, with the item's other fields alongside.
module sbi_div_step #(
  parameter int COORD_WIDTH = sbi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sbi_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  sbi_pkg::ctl_t          ctl_i,
  input  logic [sbi_pkg::side_width(COORD_WIDTH)-1:0] side_i,
  input  logic [COORD_WIDTH+1:0] r_i [sbi_pkg::NUM_PLANES],
  input  logic [COORD_WIDTH+1:0] d_i [sbi_pkg::NUM_PLANES],
  input  logic [(FRAC_BITS > 0 ? FRAC_BITS : 1)-1:0] t_i [sbi_pkg::NUM_PLANES],
  output sbi_pkg::ctl_t          ctl_o,
  output logic [sbi_pkg::side_width(COORD_WIDTH)-1:0] side_o,
  output logic [COORD_WIDTH+1:0] r_o [sbi_pkg::NUM_PLANES],
  output logic [COORD_WIDTH+1:0] d_o [sbi_pkg::NUM_PLANES],
  output logic [(FRAC_BITS > 0 ? FRAC_BITS : 1)-1:0] t_o [sbi_pkg::NUM_PLANES]
);
  import sbi_pkg::*;

  localparam int YW = COORD_WIDTH + 2;
  localparam int TW = FRAC_BITS > 0 ? FRAC_BITS : 1;
  localparam int SW = side_width(COORD_WIDTH);

  logic [YW:0]   sh_c [NUM_PLANES];
  logic [YW:0]   df_c [NUM_PLANES];
  logic [TW:0]   tq_c [NUM_PLANES];
  logic [YW-1:0] r_c  [NUM_PLANES];

  ctl_t          ctl_r;
  logic [SW-1:0] side_r;
  logic [YW-1:0] r_r [NUM_PLANES];
  logic [YW-1:0] d_r [NUM_PLANES];
  logic [TW-1:0] t_r [NUM_PLANES];

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      sh_c[p] = {r_i[p], 1'b0};
      df_c[p] = sh_c[p] - {1'b0, d_i[p]};
      if (sh_c[p] >= {1'b0, d_i[p]}) begin
        r_c[p]  = df_c[p][YW-1:0];
        tq_c[p] = {t_i[p], 1'b1};
      end else begin
        r_c[p]  = sh_c[p][YW-1:0];
        tq_c[p] = {t_i[p], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      for (int p = 0; p < NUM_PLANES; p++) begin
        r_r[p] <= r_c[p];
        d_r[p] <= d_i[p];
        t_r[p] <= tq_c[p][TW-1:0];
      end
    end
  end

  assign ctl_o  = ctl_r;
  assign side_o = side_r;
  assign r_o    = r_r;
  assign d_o    = d_r;
  assign t_o    = t_r;

endmodule

// File: sv/sbi_finish.sv
// Back stages: crossing point products, containment on the other axes, final flag.
module sbi_finish #(
  parameter int COORD_WIDTH = sbi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sbi_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  sbi_pkg::ctl_t ctl_i,
  input  logic [sbi_pkg::side_width(COORD_WIDTH)-1:0] side_i,
  input  logic [(FRAC_BITS > 0 ? FRAC_BITS : 1)-1:0] t_i [sbi_pkg::NUM_PLANES],
  output logic          valid_o,
  output logic          hit_o
);
  import sbi_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int XW = W + 1;
  localparam int YW = W + 2;
  localparam int TW = FRAC_BITS > 0 ? FRAC_BITS : 1;
  localparam int MW = XW + TW;
  localparam int SW = side_width(W);
  localparam int MAG_OFS = 9 * W;
  localparam int NEG_OFS = MAG_OFS + NUM_AXES * XW;
  localparam int CRS_OFS = NEG_OFS + NUM_AXES;
  localparam logic [MW-1:0] FMASK = ~({MW{1'b1}} << FRAC_BITS);

  logic [MW-1:0]        m_c  [NUM_PLANES][2];
  logic [MW-1:0]        m_r  [NUM_PLANES][2];
  logic [MW-1:0]        mq_c [NUM_PLANES][2];
  logic [YW-1:0]        q_c  [NUM_PLANES][2];
  logic signed [YW-1:0] h_c  [NUM_PLANES][2];
  logic                 ok_c [NUM_PLANES][2];
  logic                 any_c;
  logic                 hit_c;

  ctl_t                 ctl_a_r;
  logic [SW-1:0]        side_a_r;
  logic                 valid_r;
  logic                 hit_r;

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int i = 0; i < 2; i++) begin
        m_c[p][i] = MW'(side_i[MAG_OFS + ((p % NUM_AXES + i + 1) % NUM_AXES)*XW +: XW])
                  * MW'(t_i[p]);
      end
    end
  end

  always_comb begin
    any_c = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int i = 0; i < 2; i++) begin
        mq_c[p][i] = m_r[p][i] >> FRAC_BITS;
        q_c[p][i]  = YW'(mq_c[p][i][XW-1:0]);
        if (side_a_r[NEG_OFS + (p % NUM_AXES + i + 1) % NUM_AXES]) begin
          if (|(m_r[p][i] & FMASK)) begin
            q_c[p][i] = q_c[p][i] + YW'(1);
          end
          q_c[p][i] = -q_c[p][i];
        end
        h_c[p][i] = YW'($signed(
                      side_a_r[(2*NUM_AXES + (p % NUM_AXES + i + 1) % NUM_AXES)*W +: W]))
                  + $signed(q_c[p][i]);
        ok_c[p][i] = h_c[p][i] > YW'($signed(side_a_r[((p % NUM_AXES + i + 1) % NUM_AXES)*W +: W]))
                  && h_c[p][i] < YW'($signed(
                       side_a_r[(NUM_AXES + (p % NUM_AXES + i + 1) % NUM_AXES)*W +: W]));
      end
      if (side_a_r[CRS_OFS + p] && ok_c[p][0] && ok_c[p][1]) begin
        any_c = 1'b1;
      end
    end
    hit_c = !ctl_a_r.reject && (ctl_a_r.in_box || any_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      valid_r <= 1'b0;
    end else if (en) begin
      ctl_a_r <= ctl_i;
      valid_r <= ctl_a_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a_r <= side_i;
      m_r      <= m_c;
      hit_r    <= hit_c;
    end
  end

  assign valid_o = valid_r;
  assign hit_o   = hit_r;

endmodule
